>>> design/clex_pkg.sv
package clex_pkg;

  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LINE_W   = 24;
  localparam int unsigned COLUMN_W = 16;
  localparam int unsigned LENGTH_W = 16;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  typedef enum logic [2:0] {
    KIND_INT   = 3'd0,
    KIND_DEC   = 3'd1,
    KIND_WORD  = 3'd2,
    KIND_COMMA = 3'd3,
    KIND_NL    = 3'd4,
    KIND_END   = 3'd5,
    KIND_ERR   = 3'd6
  } clex_kind_e;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_INT  = 3'd1,
    MODE_DEC  = 3'd2,
    MODE_WORD = 3'd3,
    MODE_ERR  = 3'd4
  } clex_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } clex_in_t;

  typedef struct packed {
    clex_kind_e            token_kind;
    logic [OFFSET_W-1:0]   start_offset;
    logic [LINE_W-1:0]     start_line;
    logic [COLUMN_W-1:0]   start_column;
    logic [LENGTH_W-1:0]   token_length;
    logic                  last;
  } clex_out_t;

  typedef struct packed {
    clex_mode_e mode;
    logic       nl_pend;
  } clex_stat_t;

endpackage

>>> design/clex_core.sv
module clex_core import clex_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  clex_in_t   in_data_i,
  output clex_out_t  res0_o,
  output clex_out_t  res1_o,
  output logic [1:0] push_n_o,
  output clex_stat_t stat_o
);

  clex_mode_e          mode_q, mode_d;
  logic                nl_pend_q, nl_pend_d;
  logic [OFFSET_W-1:0] cur_off_q, cur_off_d, tok_off_q, tok_off_d, off_inc;
  logic [LINE_W-1:0]   cur_line_q, cur_line_d, tok_line_q, tok_line_d, line_inc;
  logic [COLUMN_W-1:0] cur_col_q, cur_col_d, tok_col_q, tok_col_d, col_inc;
  logic [LENGTH_W-1:0] tok_len_q, tok_len_d, len_inc;

  logic [7:0] ch;
  logic stop, digit, alpha, space, is_lf, is_comma, is_dot, word_ch;
  logic tok_mode, cont, adv;
  logic c1, c2, c3;
  logic [1:0] n;
  clex_out_t cand1, cand2, cand3;

  always_comb begin
    ch       = in_data_i.ch;
    stop     = in_data_i.is_end | (ch == CH_NUL);
    digit    = ch inside {[CH_0:CH_9]};
    alpha    = ch inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]};
    space    = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
    is_lf    = (ch == CH_LF);
    is_comma = (ch == CH_COMMA);
    is_dot   = (ch == CH_DOT);
    word_ch  = alpha | digit | (ch == CH_DASH) | (ch == CH_UNDER);

    tok_mode = (mode_q == MODE_INT) || (mode_q == MODE_DEC) || (mode_q == MODE_WORD);
    cont     = ((mode_q == MODE_INT) && (digit || is_dot)) ||
               ((mode_q == MODE_DEC) && digit) ||
               ((mode_q == MODE_WORD) && word_ch);

    // saturating position counters
    off_inc  = (cur_off_q == '1) ? cur_off_q : cur_off_q + OFFSET_W'(1);
    line_inc = (cur_line_q == '1) ? cur_line_q : cur_line_q + LINE_W'(1);
    col_inc  = (cur_col_q == '1) ? cur_col_q : cur_col_q + COLUMN_W'(1);
    len_inc  = (tok_len_q == '1) ? tok_len_q : tok_len_q + LENGTH_W'(1);

    // result candidates: closed token, pending new line, comma/error/end
    c1 = tok_mode & (stop | ~cont);
    c2 = nl_pend_q & (mode_q == MODE_IDLE) & (stop | ~space);
    c3 = stop | ((mode_q != MODE_ERR) & ~cont & ~space & ~digit & ~alpha);

    cand1.token_kind   = (mode_q == MODE_INT) ? KIND_INT :
                         (mode_q == MODE_DEC) ? KIND_DEC : KIND_WORD;
    cand1.start_offset = tok_off_q;
    cand1.start_line   = tok_line_q;
    cand1.start_column = tok_col_q;
    cand1.token_length = tok_len_q;
    cand1.last         = 1'b0;

    cand2.token_kind   = KIND_NL;
    cand2.start_offset = cur_off_q;
    cand2.start_line   = cur_line_q;
    cand2.start_column = cur_col_q;
    cand2.token_length = '0;
    cand2.last         = 1'b0;

    cand3.token_kind   = stop ? KIND_END : (is_comma ? KIND_COMMA : KIND_ERR);
    cand3.start_offset = cur_off_q;
    cand3.start_line   = cur_line_q;
    cand3.start_column = cur_col_q;
    cand3.token_length = stop ? '0 : LENGTH_W'(1);
    cand3.last         = 1'b0;

    n      = 2'(c1) + 2'(c2) + 2'(c3);
    res0_o = c1 ? cand1 : (c2 ? cand2 : cand3);
    res1_o = (c1 & c2) ? cand2 : cand3;
    res0_o.last = (n == 2'd1);
    res1_o.last = 1'b1;
    push_n_o    = accept_i ? n : 2'd0;

    // next state
    mode_d     = mode_q;
    nl_pend_d  = nl_pend_q;
    tok_off_d  = tok_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    tok_len_d  = tok_len_q;
    adv        = 1'b0;

    if (stop) begin
      mode_d     = MODE_IDLE;
      nl_pend_d  = 1'b0;
      tok_off_d  = '0;
      tok_line_d = LINE_W'(1);
      tok_col_d  = COLUMN_W'(1);
      tok_len_d  = '0;
    end else if (mode_q != MODE_ERR) begin
      if (cont) begin
        tok_len_d = len_inc;
        adv       = 1'b1;
        if ((mode_q == MODE_INT) && is_dot) begin
          mode_d = MODE_DEC;
        end
      end else begin
        mode_d = MODE_IDLE;
        if (space) begin
          nl_pend_d = nl_pend_q | is_lf;
          adv       = 1'b1;
        end else begin
          nl_pend_d = 1'b0;
          if (is_comma) begin
            adv = 1'b1;
          end else if (digit || alpha) begin
            mode_d     = digit ? MODE_INT : MODE_WORD;
            tok_off_d  = cur_off_q;
            tok_line_d = cur_line_q;
            tok_col_d  = cur_col_q;
            tok_len_d  = LENGTH_W'(1);
            adv        = 1'b1;
          end else begin
            mode_d = MODE_ERR;
          end
        end
      end
    end

    cur_off_d  = cur_off_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    if (stop) begin
      cur_off_d  = '0;
      cur_line_d = LINE_W'(1);
      cur_col_d  = COLUMN_W'(1);
    end else if (adv) begin
      cur_off_d  = off_inc;
      cur_line_d = is_lf ? line_inc : cur_line_q;
      cur_col_d  = is_lf ? COLUMN_W'(1) : col_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      nl_pend_q  <= 1'b0;
      cur_off_q  <= '0;
      cur_line_q <= LINE_W'(1);
      cur_col_q  <= COLUMN_W'(1);
      tok_off_q  <= '0;
      tok_line_q <= LINE_W'(1);
      tok_col_q  <= COLUMN_W'(1);
      tok_len_q  <= '0;
    end else if (accept_i) begin
      mode_q     <= mode_d;
      nl_pend_q  <= nl_pend_d;
      cur_off_q  <= cur_off_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_off_q  <= tok_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      tok_len_q  <= tok_len_d;
    end
  end

  assign stat_o.mode    = mode_q;
  assign stat_o.nl_pend = nl_pend_q;

endmodule

>>> design/csv_number_word_lexer.sv
// streaming lexer for csv-like text: one source byte per request in, tokens out
// (integer, decimal, word, comma, new line, end, error), each with the offset,
// line and column where it starts and its saturating length. a request is taken
// every cycle the queue has room for it; classification, position counting and
// token closing happen in one combinational pass off the lexer state registers,
// and the one or two tokens a byte causes are written into a four-entry result
// queue as the request is taken. it drains one token per cycle while out_ready_i
// is high, so the input side runs at one byte per cycle whenever the output keeps
// up; in_ready_o drops only while fewer than two queue slots are free.
// a zero byte or is_end closes the source and resets all counters.
module csv_number_word_lexer import clex_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  clex_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output clex_out_t out_data_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  logic       in_fire, out_fire;
  clex_out_t  res0, res1;
  logic [1:0] push_n;
  clex_stat_t core_stat;

  // result queue storage and pointers
  clex_out_t         q_mem [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  // accept a byte only when both of its possible tokens fit
  assign in_ready_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign out_data_o  = q_mem[rd_q];

  clex_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_fire),
    .in_data_i (in_data_i),
    .res0_o    (res0),
    .res1_o    (res1),
    .push_n_o  (push_n),
    .stat_o    (core_stat)
  );

  always_comb begin
    wr_d  = wr_q + QPtrW'(push_n);
    rd_d  = rd_q + QPtrW'(out_fire);
    cnt_d = cnt_q + QCntW'(push_n) - QCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // token entries carry no reset
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_q + QPtrW'(1)] <= res1;
    end
  end

`ifndef NO_ASSERTIONS
  a_q_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_end_gives_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.is_end || in_data_i.ch == CH_NUL)) |-> push_n != 2'd0)
    else $error("end of source produced no token");

  a_end_resets_lexer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_data_i.is_end || in_data_i.ch == CH_NUL))
      |=> (core_stat.mode == MODE_IDLE) && !core_stat.nl_pend)
    else $error("lexer not idle after end of source");
`endif

endmodule

>>> sim/tb_csv_number_word_lexer.sv
module tb_csv_number_word_lexer;
  import clex_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // watchdog: cycles with work outstanding but no handshake on either side
  localparam int unsigned STUCK_LIMIT = 1000;
  // one long word sent back to back with no gaps
  localparam int unsigned LONG_WORD   = 40;
  localparam int unsigned RAND_ITEMS  = 450;

  // whitespace codes the package leaves out
  localparam logic [7:0] CH_VT = 8'h0b;
  localparam logic [7:0] CH_FF = 8'h0c;

  typedef struct {
    clex_in_t    req;
    int unsigned gap;
  } src_item_t;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_ready;
  clex_in_t  in_data    = '0;
  logic      out_valid;
  logic      out_ready  = 1'b0;
  clex_out_t out_data;

  // pending source bytes and the tokens they are predicted to give
  src_item_t   src_q[$];
  clex_out_t   tok_q[$];
  src_item_t   drv_item;
  int unsigned hold_cnt;
  int unsigned item_cnt;
  bit          idle_on;
  bit          src_broken;
  bit          out_calm;
  int unsigned stall_cnt;
  int unsigned mon_stall;
  int unsigned stuck_cnt;
  bit          failed;
  clex_out_t   exp_tok;

  // lexer state as the predictor sees it
  clex_mode_e          lx_mode;
  logic                lx_nl;
  logic [OFFSET_W-1:0] at_off;
  logic [LINE_W-1:0]   at_line;
  logic [COLUMN_W-1:0] at_col;
  logic [OFFSET_W-1:0] tk_off;
  logic [LINE_W-1:0]   tk_line;
  logic [COLUMN_W-1:0] tk_col;
  logic [LENGTH_W-1:0] tk_len;
  int unsigned         step_cnt;

  csv_number_word_lexer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  // space, tab, line feed, vertical tab, form feed, carriage return
  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic lex_clear();
    lx_mode = MODE_IDLE;
    lx_nl   = 1'b0;
    at_off  = '0;
    at_line = LINE_W'(1);
    at_col  = COLUMN_W'(1);
    tk_off  = '0;
    tk_line = LINE_W'(1);
    tk_col  = COLUMN_W'(1);
    tk_len  = '0;
  endtask

  // each token of one request gets last, then loses it when another follows
  task automatic add_token(clex_kind_e k, logic [OFFSET_W-1:0] off,
                           logic [LINE_W-1:0] line, logic [COLUMN_W-1:0] col,
                           logic [LENGTH_W-1:0] len);
    clex_out_t t;
    t.token_kind   = k;
    t.start_offset = off;
    t.start_line   = line;
    t.start_column = col;
    t.token_length = len;
    t.last         = 1'b1;
    if (step_cnt > 0) tok_q[tok_q.size()-1].last = 1'b0;
    tok_q.push_back(t);
    step_cnt++;
  endtask

  // position moves on by one byte, all counters saturate
  task automatic step_pos(logic [7:0] c);
    if (~&at_off) at_off = at_off + 1'b1;
    if (~&at_col) at_col = at_col + 1'b1;
    if (c == CH_LF) begin
      if (~&at_line) at_line = at_line + 1'b1;
      at_col = COLUMN_W'(1);
    end
  endtask

  task automatic begin_tok(clex_mode_e m, logic [7:0] c);
    tk_off  = at_off;
    tk_line = at_line;
    tk_col  = at_col;
    tk_len  = LENGTH_W'(1);
    lx_mode = m;
    step_pos(c);
  endtask

  task automatic grow_tok(logic [7:0] c);
    if (~&tk_len) tk_len = tk_len + 1'b1;
    step_pos(c);
  endtask

  task automatic close_tok();
    clex_kind_e k;
    k = (lx_mode == MODE_INT) ? KIND_INT : (lx_mode == MODE_DEC) ? KIND_DEC : KIND_WORD;
    add_token(k, tk_off, tk_line, tk_col, tk_len);
    lx_mode = MODE_IDLE;
  endtask

  task automatic lex_byte(clex_in_t d);
    logic [7:0] c;
    bit         eos;
    c        = d.ch;
    eos      = d.is_end || (c == CH_NUL);
    step_cnt = 0;

    // end of source: flush what is pending, report end, back to reset
    if (eos) begin
      if (lx_mode == MODE_INT || lx_mode == MODE_DEC || lx_mode == MODE_WORD) begin
        close_tok();
      end else if (lx_mode == MODE_IDLE && lx_nl) begin
        add_token(KIND_NL, at_off, at_line, at_col, '0);
      end
      add_token(KIND_END, at_off, at_line, at_col, '0);
      lex_clear();
      return;
    end

    // after an error everything up to the end is dropped, position frozen
    if (lx_mode == MODE_ERR) return;

    case (lx_mode)
      MODE_INT: begin
        if (is_digit(c)) begin
          grow_tok(c);
          return;
        end
        if (c == CH_DOT) begin
          lx_mode = MODE_DEC;
          grow_tok(c);
          return;
        end
        close_tok();
      end
      MODE_DEC: begin
        if (is_digit(c)) begin
          grow_tok(c);
          return;
        end
        close_tok();
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == CH_DASH || c == CH_UNDER) begin
          grow_tok(c);
          return;
        end
        close_tok();
      end
      default: ;
    endcase

    // byte is lexed afresh from idle
    if (is_blank(c)) begin
      if (c == CH_LF) lx_nl = 1'b1;
      step_pos(c);
      return;
    end

    // a blank run with a line feed gives its token at the next real byte
    if (lx_nl) begin
      add_token(KIND_NL, at_off, at_line, at_col, '0);
      lx_nl = 1'b0;
    end

    if (c == CH_COMMA) begin
      add_token(KIND_COMMA, at_off, at_line, at_col, LENGTH_W'(1));
      step_pos(c);
    end else if (is_digit(c)) begin
      begin_tok(MODE_INT, c);
    end else if (is_alpha(c)) begin
      begin_tok(MODE_WORD, c);
    end else begin
      add_token(KIND_ERR, at_off, at_line, at_col, LENGTH_W'(1));
      lx_mode = MODE_ERR;
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------

  task automatic push_byte(logic [7:0] c, bit e);
    src_item_t it;
    it.req.ch     = c;
    it.req.is_end = e;
    it.gap        = idle_on ? $urandom_range(0, 3) : 0;
    src_q.push_back(it);
    // bytes after an injected bad one are only ignored by the lexer
    if (!src_broken) item_cnt++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return CH_UA + 8'($urandom_range(0, 25));
    return CH_LA + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_word_ch();
    case ($urandom_range(0, 3))
      0:       return rand_letter();
      1:       return rand_digit();
      2:       return CH_DASH;
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      3:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // integer, decimal (maybe with no fraction digits), word or empty field
  task automatic gen_field();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 3))
      0: repeat (n) push_byte(rand_digit(), 1'b0);
      1: begin
        repeat (n) push_byte(rand_digit(), 1'b0);
        push_byte(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 3)) push_byte(rand_digit(), 1'b0);
      end
      2: begin
        push_byte(rand_letter(), 1'b0);
        repeat (n - 1) push_byte(rand_word_ch(), 1'b0);
      end
      default: ;
    endcase
  endtask

  // one source: mostly rows of fields, now and then pure noise
  task automatic gen_source();
    int rows;
    int flds;
    src_broken = 1'b0;
    idle_on    = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(3, 10)) begin
        push_byte(8'($urandom_range(1, 255)), 1'b0);
        src_broken = 1'b1;
      end
    end else begin
      rows = $urandom_range(1, 4);
      repeat (rows) begin
        flds = $urandom_range(1, 4);
        for (int f = 0; f < flds; f++) begin
          if (f > 0) push_byte(CH_COMMA, 1'b0);
          if ($urandom_range(0, 3) == 0) push_byte(rand_blank(), 1'b0);
          gen_field();
          if ($urandom_range(0, 3) == 0) push_byte(rand_blank(), 1'b0);
          if ($urandom_range(0, 11) == 0) begin
            push_byte(8'($urandom_range(1, 255)), 1'b0);
            src_broken = 1'b1;
          end
        end
        // row ending: lf, crlf, blank line, lf with trailing blank, or none
        case ($urandom_range(0, 4))
          0: push_byte(CH_LF, 1'b0);
          1: begin
            push_byte(CH_CR, 1'b0);
            push_byte(CH_LF, 1'b0);
          end
          2: begin
            push_byte(CH_LF, 1'b0);
            push_byte(CH_LF, 1'b0);
          end
          3: begin
            push_byte(CH_LF, 1'b0);
            push_byte(rand_blank(), 1'b0);
          end
          default: ;
        endcase
      end
    end
    // end by flag with any byte, or by a zero byte
    if ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)), 1'b1);
    else push_byte(CH_NUL, 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      hold_cnt <= 0;
    end else begin
      // accepted request goes through the predictor right here
      if (in_valid && in_ready) lex_byte(in_data);
      // next request only once the current one is gone; valid stays up back to back
      if (!in_valid || in_ready) begin
        if (src_q.size() > 0 && hold_cnt >= src_q[0].gap) begin
          drv_item = src_q.pop_front();
          in_data  <= drv_item.req;
          in_valid <= 1'b1;
          hold_cnt <= 0;
        end else begin
          in_valid <= 1'b0;
          if (src_q.size() > 0) hold_cnt <= hold_cnt + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // token monitor
  // ---------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tok_q.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d offset %0d",
                   $realtime, out_data.token_kind, out_data.start_offset);
          failed = 1'b1;
        end else begin
          exp_tok = tok_q.pop_front();
          check_field("token_kind", 64'(exp_tok.token_kind), 64'(out_data.token_kind));
          check_field("start_offset", 64'(exp_tok.start_offset),
                      64'(out_data.start_offset));
          check_field("start_line", 64'(exp_tok.start_line), 64'(out_data.start_line));
          check_field("start_column", 64'(exp_tok.start_column),
                      64'(out_data.start_column));
          check_field("token_length", 64'(exp_tok.token_length),
                      64'(out_data.token_length));
          check_field("last", 64'(exp_tok.last), 64'(out_data.last));
        end
        // now and then switch between stalling and a stretch of full speed
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        mon_stall = out_calm ? 0 : $urandom_range(0, 3);
        stall_cnt <= mon_stall;
        out_ready <= (mon_stall == 0);
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_ready <= (stall_cnt == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && (src_q.size() > 0 || in_valid || tok_q.size() > 0) &&
        !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      stuck_cnt++;
      if (stuck_cnt >= STUCK_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, stuck_cnt);
        $display("Simulation FAILED");
        $finish;
      end
    end else begin
      stuck_cnt = 0;
    end
  end

  // ---------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------

  initial begin
    lex_clear();
    failed     = 1'b0;
    out_calm   = 1'b0;
    stuck_cnt  = 0;
    item_cnt   = 0;
    src_broken = 1'b0;
    idle_on    = 1'b1;

    // decimal closed by a comma, decimal with no fraction digits, crlf run,
    // new line then a word using every tail class, word closed by the end flag
    push_text("12.5,9. \n\r\nA_-z0");
    push_byte(8'hff, 1'b1);
    // new line left pending at a zero byte
    push_text("\t\n");
    push_byte(CH_NUL, 1'b0);
    // integer closed by a bad byte, byte ignored after it, end at frozen position
    push_text("3");
    push_byte(8'hff, 1'b0);
    push_text("x");
    push_byte(CH_NUL, 1'b0);
    // lone dot is an error, end flag with a digit byte
    push_byte(CH_DOT, 1'b0);
    push_byte("1", 1'b1);

    // one long word at full speed
    idle_on = 1'b0;
    push_byte(rand_letter(), 1'b0);
    repeat (LONG_WORD - 1) push_byte(rand_word_ch(), 1'b0);
    push_byte(CH_COMMA, 1'b0);
    push_byte(CH_NUL, 1'b0);

    // random sources
    while (item_cnt < RAND_ITEMS) gen_source();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain, then wait on for stray tokens
    while (src_q.size() != 0 || in_valid || tok_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
